// ===== rtl/fatlb_pkg.sv =====
// shared types and constants for the fully associative tlb
// no dependencies
`default_nettype none

package fatlb_pkg;

    localparam int AddrW          = 32;
    localparam int OffW           = 12;
    localparam int PageW          = AddrW - OffW;
    localparam int PermW          = 4;
    localparam int ModePermW      = 2;
    localparam int DefaultEntries = 8;

    typedef enum logic [1:0] {
        OP_TRANSLATE  = 2'd0,
        OP_STAGE      = 2'd1,
        OP_WRITE_PHYS = 2'd2,
        OP_INVALIDATE = 2'd3
    } t_opcode;

    // write / flush command into the entry array
    typedef struct packed {
        logic             wr_en;
        logic             inv_en;
        logic [PageW-1:0] wr_page;
        logic [PermW-1:0] wr_perm;
        logic [PageW-1:0] wr_frame;
    } t_cam_cmd;

    // lookup answer from the entry array
    typedef struct packed {
        logic             hit;
        logic [PageW-1:0] frame;
        logic [PermW-1:0] perm;
        logic             any_valid;
    } t_cam_look;

endpackage

`default_nettype wire

// ===== rtl/fatlb_ifs.sv =====
// valid/ready channel interfaces for tlb requests and responses
// depends on fatlb_pkg
`default_nettype none

interface fatlb_req_if import fatlb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [AddrW-1:0] address;
    logic             user_mode;

    modport source (output valid, output opcode, output address, output user_mode,
                    input ready);
    modport sink   (input valid, input opcode, input address, input user_mode,
                    output ready);
endinterface

interface fatlb_rsp_if import fatlb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [AddrW-1:0]     phys_address;
    logic [ModePermW-1:0] permissions;

    modport source (output valid, output hit, output phys_address, output permissions,
                    input ready);
    modport sink   (input valid, input hit, input phys_address, input permissions,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/fatlb_cam.sv =====
// tlb entry array: parallel page compare, lowest-index select, round-robin victim
// depends on fatlb_pkg
`default_nettype none

module fatlb_cam import fatlb_pkg::*; #(
    parameter int ENTRIES = DefaultEntries
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [PageW-1:0] i_page,
    input  wire t_cam_cmd         i_cmd,
    output t_cam_look             o_look
);

    localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] n_valid;
    logic [PageW-1:0]   r_page  [ENTRIES];
    logic [PermW-1:0]   r_perm  [ENTRIES];
    logic [PageW-1:0]   r_frame [ENTRIES];
    logic [IdxW-1:0]    r_victim;
    logic [IdxW-1:0]    n_victim;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] first;
    logic [ENTRIES-1:0] vsel;
    logic [ENTRIES-1:0] wsel;
    logic [PageW-1:0]   sel_frame;
    logic [PermW-1:0]   sel_perm;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_page[i] == i_page);
            vsel[i]  = (r_victim == IdxW'(i));
        end
    end

    // isolate lowest set bit
    assign first = match & (~match + ENTRIES'(1));

    always_comb begin
        sel_frame = '0;
        sel_perm  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            sel_frame = sel_frame | ({PageW{first[i]}} & r_frame[i]);
            sel_perm  = sel_perm  | ({PermW{first[i]}} & r_perm[i]);
        end
    end

    assign wsel = (|match) ? first : vsel;

    always_comb begin
        o_look.hit       = |match;
        o_look.frame     = sel_frame;
        o_look.perm      = sel_perm;
        o_look.any_valid = |r_valid;
    end

    always_comb begin
        n_valid  = r_valid;
        n_victim = r_victim;
        if (i_cmd.inv_en) begin
            n_valid = '0;
        end else if (i_cmd.wr_en) begin
            n_valid  = r_valid | wsel;
            n_victim = (r_victim == IdxW'(ENTRIES - 1)) ? '0 : r_victim + IdxW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_victim <= '0;
        end else begin
            r_valid  <= n_valid;
            r_victim <= n_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.wr_en && wsel[i]) begin
                r_page[i]  <= i_cmd.wr_page;
                r_perm[i]  <= i_cmd.wr_perm;
                r_frame[i] <= i_cmd.wr_frame;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fully_assoc_tlb_round_robin.sv =====
// fully associative tlb with round-robin replacement, top level
// depends on fatlb_pkg, fatlb_ifs, fatlb_cam
//
// usage
//   i_req carries one operation per beat: translate, stage a virtual word,
//   write a physical frame for the staged page, or invalidate all entries
//   o_rsp carries one beat per translate (hit, phys_address, permissions);
//   the other operations produce no response beat
// throughput
//   a translate result is registered into the response register on o_rsp,
//   or into the skid while that register holds an untaken beat; one operation
//   per cycle is accepted while i_req.ready is high, all entries compared in
//   parallel; state updates (stage, write, invalidate) take effect at the
//   accepting edge, so the very next operation already sees them
// stall behavior
//   a response register plus a one-deep skid register sit on o_rsp; while
//   the receiver stalls, one more translate is still taken into the skid,
//   after that i_req.ready drops until the skid drains
// reset
//   i_rst_n (synchronous, active low) clears all valid bits, the victim
//   pointer, the staged virtual word and the valid bits of both response registers
`default_nettype none

module fully_assoc_tlb_round_robin import fatlb_pkg::*; #(
    parameter int ENTRIES = DefaultEntries
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    fatlb_req_if.sink    i_req,
    fatlb_rsp_if.source  o_rsp
);

    // staged virtual word: page plus four permission bits
    logic [PageW-1:0] r_stg_page;
    logic [PermW-1:0] r_stg_perm;

    // response register and skid stage
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [AddrW-1:0]     r_out_phys;
    logic [ModePermW-1:0] r_out_perm;
    logic                 r_skid_valid;
    logic                 r_skid_hit;
    logic [AddrW-1:0]     r_skid_phys;
    logic [ModePermW-1:0] r_skid_perm;

    logic                 push;
    logic                 take;
    logic                 is_xlate;
    logic                 rsp_push;
    logic [PageW-1:0]     look_page;
    t_cam_cmd             cmd;
    t_cam_look            look;
    logic                 res_hit;
    logic [AddrW-1:0]     res_phys;
    logic [ModePermW-1:0] res_perm;

    assign i_req.ready = !r_skid_valid;
    assign push        = i_req.valid && i_req.ready;
    assign take        = r_out_valid && o_rsp.ready;
    assign is_xlate    = (t_opcode'(i_req.opcode) == OP_TRANSLATE);
    assign rsp_push    = push && is_xlate;

    // a write looks up the staged page, everything else the request page
    assign look_page = (t_opcode'(i_req.opcode) == OP_WRITE_PHYS) ? r_stg_page
                                                                   : i_req.address[AddrW-1:OffW];

    always_comb begin
        cmd.wr_en    = push && (t_opcode'(i_req.opcode) == OP_WRITE_PHYS);
        cmd.inv_en   = push && (t_opcode'(i_req.opcode) == OP_INVALIDATE);
        cmd.wr_page  = r_stg_page;
        cmd.wr_perm  = r_stg_perm;
        cmd.wr_frame = i_req.address[AddrW-1:OffW];
    end

    fatlb_cam #(
        .ENTRIES (ENTRIES)
    ) u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_page  (look_page),
        .i_cmd   (cmd),
        .o_look  (look)
    );

    // translate result; miss returns all zeros
    always_comb begin
        res_hit  = look.hit;
        res_phys = '0;
        res_perm = '0;
        if (look.hit) begin
            res_phys = {look.frame, i_req.address[OffW-1:0]};
            res_perm = i_req.user_mode ? look.perm[PermW-1:ModePermW]
                                       : look.perm[ModePermW-1:0];
        end
    end

    // staging register, bits 11:4 of the staged word are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_page <= '0;
            r_stg_perm <= '0;
        end else if (push && (t_opcode'(i_req.opcode) == OP_STAGE)) begin
            r_stg_page <= i_req.address[AddrW-1:OffW];
            r_stg_perm <= i_req.address[PermW-1:0];
        end
    end

    // output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (rsp_push) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_hit  <= r_skid_hit;
                r_out_phys <= r_skid_phys;
                r_out_perm <= r_skid_perm;
            end
        end else if (rsp_push) begin
            if (r_out_valid && !take) begin
                r_skid_hit  <= res_hit;
                r_skid_phys <= res_phys;
                r_skid_perm <= res_perm;
            end else begin
                r_out_hit  <= res_hit;
                r_out_phys <= res_phys;
                r_out_perm <= res_perm;
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.phys_address = r_out_phys;
    assign o_rsp.permissions  = r_out_perm;

    // skid only ever holds the younger of two waiting beats
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while the response register is empty");

    // a flush leaves no valid entry behind
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.inv_en |=> !look.any_valid)
        else $error("entries still valid after invalidate");

    // an accepted translate always shows up as a response beat
    a_xlate_responds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_push |=> r_out_valid)
        else $error("translate accepted but no response pending");

    // a write always leaves at least one valid entry
    a_write_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |=> look.any_valid)
        else $error("no valid entry after a physical write");

endmodule

`default_nettype wire
